// ===== rtl/lhbp_pkg.sv =====
`timescale 1ns / 1ps
// lhbp_pkg: shared types, constants and the counter update function
// for the local history branch predictor. No dependencies.
package lhbp_pkg;

  // running total width and its saturation value
  localparam int COUNT_BITS = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // branch address width on the input port
  localparam int ADDR_PORT_BITS = 32;

  // 2-bit counter encoding and the value after reset
  localparam int CTR_BITS = 2;
  localparam logic [CTR_BITS-1:0] CTR_RESET = 2'd3;

  // control states
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HIST  = 4'b0100,
    ST_PATT  = 4'b1000
  } state_t;

  // update request to the running totals
  typedef struct packed {
    logic count;
    logic hit;
  } stat_upd_t;

  // hysteresis counter transition
  function automatic logic [CTR_BITS-1:0] next_counter(input logic [CTR_BITS-1:0] c,
                                                       input logic t);
    logic [CTR_BITS-1:0] n;
    n = 2'd0;
    case (c) inside
      2'd3: begin
        n = t ? 2'd3 : 2'd2;
      end
      2'd2, 2'd1: begin
        n = t ? 2'd3 : 2'd0;
      end
      default: begin
        n = t ? 2'd1 : 2'd0;
      end
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/local_history_branch_predictor.sv =====
`timescale 1ns / 1ps
// local_history_branch_predictor: top level, control sequencer and table update.
// Depends on lhbp_pkg, lhbp_ram and lhbp_stats.
//
// Usage:
//   Input channel: drive branch_address and taken and raise start; the
//   transfer happens at a rising edge where start is high and busy is low.
//   Result channel: valid is high for exactly one cycle with
//   predicted_taken, counter_value, prediction_correct, branches_seen and
//   correct_total. The receiver cannot stall; the result must be taken then.
//   Sequence: the history table read, the dependent pattern table read and
//   the write-back run in turn through ST_HIST and ST_PATT; valid is
//   registered from the write-back. busy is high until then, so a new item
//   waits for the last; its history read overlaps the cycle valid is shown.
//   Reset: rst is synchronous. After reset the block sweeps both tables,
//   one entry per cycle, over 2^max(HISTORY_TABLE_INDEX_BITS,
//   PATTERN_TABLE_INDEX_BITS) indices (1024 with the defaults), setting
//   histories to zero and counters to strongly taken. busy is high during
//   the sweep. Running totals saturate at all ones.
module local_history_branch_predictor #(
  parameter int HISTORY_TABLE_INDEX_BITS = 5,
  parameter int HISTORY_BITS             = 2,
  parameter int PATTERN_TABLE_INDEX_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lhbp_pkg::ADDR_PORT_BITS-1:0]  branch_address,
  input  logic                                 taken,
  output logic                                 valid,
  output logic                                 predicted_taken,
  output logic [lhbp_pkg::CTR_BITS-1:0]        counter_value,
  output logic                                 prediction_correct,
  output logic [lhbp_pkg::COUNT_BITS-1:0]      branches_seen,
  output logic [lhbp_pkg::COUNT_BITS-1:0]      correct_total
);

  localparam int HT = HISTORY_TABLE_INDEX_BITS;
  localparam int HB = HISTORY_BITS;
  localparam int PT = PATTERN_TABLE_INDEX_BITS;
  localparam int ADDR_PART = (PT > HB) ? (PT - HB) : 0;
  localparam int CLR_BITS = (HT > PT) ? HT : PT;
  localparam logic [PT-1:0] ADDR_MASK = (PT'(1) << ADDR_PART) - PT'(1);

  lhbp_pkg::state_t state, state_next;

  logic [CLR_BITS-1:0]          clr_idx;
  logic [HT-1:0]                hidx;
  logic [PT-1:0]                alow;
  logic                         taken_r;
  logic [HB-1:0]                hist;
  logic [PT-1:0]                pidx;

  logic                         accept;
  logic [HB-1:0]                hist_rdata;
  logic [lhbp_pkg::CTR_BITS-1:0] ctr_rdata;
  logic [PT+HB-1:0]             hist_shift;
  logic [PT-1:0]                pidx_calc;
  logic                         pred;
  logic                         ok;
  logic                         clearing;
  logic                         updating;

  logic                         hist_we;
  logic [HT-1:0]                hist_waddr;
  logic [HB-1:0]                hist_wdata;
  logic                         pat_we;
  logic [PT-1:0]                pat_waddr;
  logic [lhbp_pkg::CTR_BITS-1:0] pat_wdata;

  lhbp_pkg::stat_upd_t          upd;

  assign busy     = (state != lhbp_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign clearing = (state == lhbp_pkg::ST_CLEAR);
  assign updating = (state == lhbp_pkg::ST_PATT);

  // pattern index: history above the low address bits
  assign hist_shift = {{PT{1'b0}}, hist_rdata} << ADDR_PART;
  assign pidx_calc  = hist_shift[PT-1:0] | (alow & ADDR_MASK);

  // prediction from the counter read
  assign pred = ctr_rdata[1];
  assign ok   = (pred == taken_r);

  // write-back, or initial values during the sweep
  assign hist_we    = clearing || updating;
  assign hist_waddr = clearing ? clr_idx[HT-1:0] : hidx;
  assign hist_wdata = clearing ? '0 : HB'({hist, taken_r});
  assign pat_we     = clearing || updating;
  assign pat_waddr  = clearing ? clr_idx[PT-1:0] : pidx;
  assign pat_wdata  = clearing ? lhbp_pkg::CTR_RESET
                               : lhbp_pkg::next_counter(ctr_rdata, taken_r);

  // local history table
  lhbp_ram #(
    .ADDR_BITS (HT),
    .DATA_BITS (HB)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (branch_address[HT-1:0]),
    .rdata (hist_rdata)
  );

  // pattern counter table
  lhbp_ram #(
    .ADDR_BITS (PT),
    .DATA_BITS (lhbp_pkg::CTR_BITS)
  ) u_pattern (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (pidx_calc),
    .rdata (ctr_rdata)
  );

  // running totals
  assign upd.count = updating;
  assign upd.hit   = updating && ok;

  lhbp_stats u_stats (
    .clk          (clk),
    .rst          (rst),
    .upd          (upd),
    .branch_count (branches_seen),
    .hit_count    (correct_total)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      lhbp_pkg::ST_CLEAR: begin
        if (clr_idx == {CLR_BITS{1'b1}}) begin
          state_next = lhbp_pkg::ST_IDLE;
        end
      end
      lhbp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lhbp_pkg::ST_HIST;
        end
      end
      lhbp_pkg::ST_HIST: begin
        state_next = lhbp_pkg::ST_PATT;
      end
      lhbp_pkg::ST_PATT: begin
        state_next = lhbp_pkg::ST_IDLE;
      end
      default: begin
        state_next = lhbp_pkg::ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lhbp_pkg::ST_CLEAR;
      clr_idx <= '0;
      valid   <= 1'b0;
    end else begin
      state <= state_next;
      valid <= updating;
      if (clearing) begin
        clr_idx <= clr_idx + CLR_BITS'(1);
      end
    end
  end

  // item payload through the stages
  always_ff @(posedge clk) begin
    if (accept) begin
      hidx    <= branch_address[HT-1:0];
      alow    <= branch_address[PT-1:0];
      taken_r <= taken;
    end
    if (state == lhbp_pkg::ST_HIST) begin
      hist <= hist_rdata;
      pidx <= pidx_calc;
    end
    if (updating) begin
      predicted_taken    <= pred;
      counter_value      <= ctr_rdata;
      prediction_correct <= ok;
    end
  end

`ifndef SYNTHESIS
  // a result is shown only after the write-back, with the sequencer free again
  a_valid_after_update: assert property (@(posedge clk) disable iff (rst)
    valid |-> (state == lhbp_pkg::ST_IDLE) && ($past(state) == lhbp_pkg::ST_PATT))
    else $error("result strobe without a preceding update cycle");

  // an accepted item walks the two reads in order
  a_accept_to_patt: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == lhbp_pkg::ST_HIST) ##1 (state == lhbp_pkg::ST_PATT))
    else $error("accepted item did not reach the update cycle");

  // prediction consistent with the counter shown
  a_pred_from_counter: assert property (@(posedge clk) disable iff (rst)
    valid |-> (predicted_taken == counter_value[1]))
    else $error("prediction does not match counter value");

  // the branch total moves only on an update
  a_total_moves_on_update: assert property (@(posedge clk) disable iff (rst)
    (state != lhbp_pkg::ST_PATT) |=> $stable(branches_seen))
    else $error("branch total changed outside an update");

  // correct total never passes the branch total
  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    valid |-> (correct_total <= branches_seen))
    else $error("correct total exceeds branch total");
`endif

endmodule

// ===== rtl/lhbp_ram.sv =====
`timescale 1ns / 1ps
// lhbp_ram: single write port, single read port memory with registered read data.
// No dependencies.
module lhbp_ram #(
  parameter int ADDR_BITS = 5,
  parameter int DATA_BITS = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lhbp_stats.sv =====
`timescale 1ns / 1ps
// lhbp_stats: saturating running totals of branches and correct predictions.
// Depends on lhbp_pkg.
module lhbp_stats (
  input  logic                               clk,
  input  logic                               rst,
  input  lhbp_pkg::stat_upd_t                upd,
  output logic [lhbp_pkg::COUNT_BITS-1:0]    branch_count,
  output logic [lhbp_pkg::COUNT_BITS-1:0]    hit_count
);

  logic [lhbp_pkg::COUNT_BITS-1:0] branch_count_next;
  logic [lhbp_pkg::COUNT_BITS-1:0] hit_count_next;

  // saturating increments
  always_comb begin
    branch_count_next = branch_count;
    hit_count_next    = hit_count;
    if (upd.count && (branch_count != lhbp_pkg::COUNT_MAX)) begin
      branch_count_next = branch_count + lhbp_pkg::COUNT_BITS'(1);
    end
    if (upd.hit && (hit_count != lhbp_pkg::COUNT_MAX)) begin
      hit_count_next = hit_count + lhbp_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      branch_count <= '0;
      hit_count    <= '0;
    end else begin
      branch_count <= branch_count_next;
      hit_count    <= hit_count_next;
    end
  end

endmodule

// ===== verif/lhbp_checker.sv =====
`timescale 1ns / 1ps
// lhbp_checker: watches both channels of local_history_branch_predictor,
// predicts each result and compares it field by field. Depends on lhbp_pkg.
module lhbp_checker #(
  parameter int HISTORY_TABLE_INDEX_BITS = 5,
  parameter int HISTORY_BITS             = 2,
  parameter int PATTERN_TABLE_INDEX_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [lhbp_pkg::ADDR_PORT_BITS-1:0] branch_address,
  input  logic                                taken,
  input  logic                                valid,
  input  logic                                predicted_taken,
  input  logic [lhbp_pkg::CTR_BITS-1:0]       counter_value,
  input  logic                                prediction_correct,
  input  logic [lhbp_pkg::COUNT_BITS-1:0]     branches_seen,
  input  logic [lhbp_pkg::COUNT_BITS-1:0]     correct_total,
  output int                                  mismatches,
  output int                                  pending
);
  import lhbp_pkg::*;

  localparam int LHT_ENTRIES = 1 << HISTORY_TABLE_INDEX_BITS;
  localparam int PHT_ENTRIES = 1 << PATTERN_TABLE_INDEX_BITS;
  // address bits placed under the history in the pattern index
  localparam int ADDR_PART = (PATTERN_TABLE_INDEX_BITS > HISTORY_BITS) ?
                             (PATTERN_TABLE_INDEX_BITS - HISTORY_BITS) : 0;

  typedef struct packed {
    logic                  pred;
    logic [CTR_BITS-1:0]   ctr;
    logic                  ok;
    logic [COUNT_BITS-1:0] seen;
    logic [COUNT_BITS-1:0] hits;
  } branch_outcome_t;

  logic [HISTORY_BITS-1:0] history_table [LHT_ENTRIES];
  logic [CTR_BITS-1:0]     counter_table [PHT_ENTRIES];
  logic [COUNT_BITS-1:0]   branch_total;
  logic [COUNT_BITS-1:0]   hit_total;
  branch_outcome_t         outcomes_due [$];
  int                      fail_count = 0;

  assign mismatches = fail_count;

  // look up, update the tables and totals, and return what the block should show
  function automatic branch_outcome_t resolve_branch(input logic [ADDR_PORT_BITS-1:0] addr,
                                                     input logic t);
    branch_outcome_t         res;
    int                      hidx;
    int                      pidx;
    logic [HISTORY_BITS-1:0] hist;
    longint unsigned         addr_low;
    hidx     = int'(addr) & (LHT_ENTRIES - 1);
    hist     = history_table[hidx];
    addr_low = longint'(addr) & ((64'd1 << ADDR_PART) - 64'd1);
    pidx     = int'(((longint'(hist) << ADDR_PART) | addr_low) & (PHT_ENTRIES - 1));
    res.ctr  = counter_table[pidx];
    res.pred = res.ctr[1];
    res.ok   = (res.pred == t);
    // hysteresis: taken jumps to strong unless at zero, not taken drops to zero unless at three
    if (t) begin
      counter_table[pidx] = (res.ctr == 2'd0) ? 2'd1 : 2'd3;
    end else begin
      counter_table[pidx] = (res.ctr == 2'd3) ? 2'd2 : 2'd0;
    end
    history_table[hidx] = HISTORY_BITS'({hist, t});
    if (branch_total != COUNT_MAX) branch_total = branch_total + COUNT_BITS'(1);
    if (res.ok && hit_total != COUNT_MAX) hit_total = hit_total + COUNT_BITS'(1);
    res.seen = branch_total;
    res.hits = hit_total;
    return res;
  endfunction

  function automatic void check_field(input string name, input longint unsigned expv,
                                      input longint unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      fail_count++;
    end
  endfunction

  // result check first, then the input transfer of the same edge
  always @(posedge clk) begin
    branch_outcome_t want;
    if (rst) begin
      foreach (history_table[i]) history_table[i] = '0;
      foreach (counter_table[i]) counter_table[i] = CTR_RESET;
      branch_total = '0;
      hit_total    = '0;
      outcomes_due.delete();
    end else begin
      if (valid) begin
        if (outcomes_due.size() == 0) begin
          $error("result transfer with no branch outstanding");
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("predicted_taken", want.pred, predicted_taken);
          check_field("counter_value", want.ctr, counter_value);
          check_field("prediction_correct", want.ok, prediction_correct);
          check_field("branches_seen", want.seen, branches_seen);
          check_field("correct_total", want.hits, correct_total);
        end
      end
      if (start && !busy) begin
        outcomes_due.push_back(resolve_branch(branch_address, taken));
      end
    end
    pending <= outcomes_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: clock, reset, branch stream and verdict for local_history_branch_predictor.
// Depends on lhbp_pkg, the block and lhbp_checker.
module tb_top;
  import lhbp_pkg::*;

  localparam int HIST_IDX_BITS = 5;
  localparam int HIST_BITS     = 2;
  localparam int PATT_IDX_BITS = 10;
  localparam int BRANCH_ITEMS  = 1450;
  localparam int POOL_SIZE     = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic                      clk            = 1'b0;
  logic                      rst            = 1'b1;
  logic                      start          = 1'b0;
  logic [ADDR_PORT_BITS-1:0] branch_address = '0;
  logic                      taken          = 1'b0;
  logic                      busy;
  logic                      valid;
  logic                      predicted_taken;
  logic [CTR_BITS-1:0]       counter_value;
  logic                      prediction_correct;
  logic [COUNT_BITS-1:0]     branches_seen;
  logic [COUNT_BITS-1:0]     correct_total;
  int                        mismatches;
  int                        pending;
  int                        cycle_count = 0;
  int                        sent        = 0;
  logic [ADDR_PORT_BITS-1:0] addr_pool [POOL_SIZE];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  local_history_branch_predictor #(
    .HISTORY_TABLE_INDEX_BITS (HIST_IDX_BITS),
    .HISTORY_BITS             (HIST_BITS),
    .PATTERN_TABLE_INDEX_BITS (PATT_IDX_BITS)
  ) i_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .branch_address     (branch_address),
    .taken              (taken),
    .valid              (valid),
    .predicted_taken    (predicted_taken),
    .counter_value      (counter_value),
    .prediction_correct (prediction_correct),
    .branches_seen      (branches_seen),
    .correct_total      (correct_total)
  );

  lhbp_checker #(
    .HISTORY_TABLE_INDEX_BITS (HIST_IDX_BITS),
    .HISTORY_BITS             (HIST_BITS),
    .PATTERN_TABLE_INDEX_BITS (PATT_IDX_BITS)
  ) i_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .branch_address     (branch_address),
    .taken              (taken),
    .valid              (valid),
    .predicted_taken    (predicted_taken),
    .counter_value      (counter_value),
    .prediction_correct (prediction_correct),
    .branches_seen      (branches_seen),
    .correct_total      (correct_total),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // hold one branch on the inputs until its transfer, return at the next falling edge
  task automatic send_branch(input logic [ADDR_PORT_BITS-1:0] addr, input logic t);
    start          = 1'b1;
    branch_address = addr;
    taken          = t;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
  endtask

  // idle gap of length n: start low, junk on the data inputs
  task automatic idle_gap(input int n);
    if (n > 0) start = 1'b0;
    repeat (n) begin
      branch_address = $urandom;
      taken          = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : stimulus
    logic [ADDR_PORT_BITS-1:0] addr;
    logic [3:0]                pattern;
    int                        period;
    int                        len;
    int                        base;
    bit                        gaps_on;
    bit                        interleave;
    bit                        drained;
    drained = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // counter walk at history slot zero: 3->2, 2->0, 0->0, 0->1, then 1->3, 2->3, 3->3
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    // all-ones address, ending with 1->0
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    // alternating bits and single high/low bits, aliasing on the history slot
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    send_branch(32'h8000_0000, 1'b0);
    send_branch(32'h7FFF_FFFF, 1'b1);
    send_branch(32'h0000_0020, 1'b1);
    send_branch(32'h0000_0100, 1'b0);
    idle_gap(3);

    foreach (addr_pool[i]) addr_pool[i] = $urandom;

    // loop-like bursts on a small address pool, with some noise branches
    while (sent < BRANCH_ITEMS) begin
      if (!drained && sent >= BRANCH_ITEMS / 2) begin
        start = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        base       = $urandom_range(0, POOL_SIZE - 2);
        pattern    = 4'($urandom);
        period     = $urandom_range(1, 4);
        len        = $urandom_range(4, 16);
        gaps_on    = ($urandom_range(0, 3) != 0);
        interleave = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < len; k++) begin
          addr = addr_pool[base + ((interleave && k[0]) ? 1 : 0)];
          send_branch(addr, pattern[k % period] ^ ($urandom_range(0, 19) == 0));
          if (gaps_on) idle_gap(pick_gap());
        end
      end else begin
        send_branch($urandom, 1'($urandom_range(0, 1)));
        idle_gap(pick_gap());
      end
      if ($urandom_range(0, 15) == 0) addr_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
    end

    // drain and verdict
    start = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lhbp_pkg.sv
rtl/lhbp_ram.sv
rtl/lhbp_stats.sv
rtl/local_history_branch_predictor.sv
verif/lhbp_checker.sv
verif/tb_top.sv
